[sv/rhcs_pkg.sv]
`timescale 1ns / 1ps

package rhcs_pkg;

    localparam int MAX_REPORT_BYTES_DEF = 4096;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [15:0] CELL_MAX  = 16'hffff;

    localparam int COUNT_W = 12;
    localparam int CELL_W  = 16;
    localparam int SUM_W   = 27;
    localparam int HASH_W  = 32;

    // result fields, lowest bits first, padded to whole bytes
    localparam int RESULT_W   = HASH_W + 2 * COUNT_W + 2 * CELL_W + SUM_W;
    localparam int RESULT_PAD = ((RESULT_W + 7) / 8) * 8 - RESULT_W;
    localparam int TDATA_W    = RESULT_W + RESULT_PAD;

    // one byte moving from the input register into the accumulators
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } step_t;

    typedef struct packed {
        logic [COUNT_W-1:0] cell_count;
        logic [COUNT_W-1:0] nonzero_count;
        logic [CELL_W-1:0]  min_cell;
        logic [CELL_W-1:0]  max_cell;
        logic [SUM_W-1:0]   cell_sum;
    } stats_t;

endpackage

[sv/rhcs_fnv.sv]
`timescale 1ns / 1ps

module rhcs_fnv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rhcs_pkg::step_t             step,
    output logic [rhcs_pkg::HASH_W-1:0] hash_upd
);

    logic [rhcs_pkg::HASH_W-1:0] hash_reg;
    logic [rhcs_pkg::HASH_W-1:0] hash_next;

    // constant multiply, kept modulo 2^32
    assign hash_upd = (hash_reg ^ {24'd0, step.data}) * rhcs_pkg::FNV_PRIME;

    always_comb begin
        hash_next = hash_reg;
        if (step.valid) begin
            hash_next = step.last ? rhcs_pkg::FNV_BASIS : hash_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= rhcs_pkg::FNV_BASIS;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

[sv/rhcs_cell_stats.sv]
`timescale 1ns / 1ps

module rhcs_cell_stats #(
    parameter int MAX_REPORT_BYTES = rhcs_pkg::MAX_REPORT_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rhcs_pkg::step_t  step,
    output rhcs_pkg::stats_t stats_upd
);

    localparam int CellCapInt = (MAX_REPORT_BYTES / 2 > 4095) ? 4095 : MAX_REPORT_BYTES / 2;
    localparam longint SumCapRaw = longint'(CellCapInt) * 65535;
    localparam longint SumCapLong = (SumCapRaw > 134217727) ? 134217727 : SumCapRaw;
    localparam logic [rhcs_pkg::COUNT_W-1:0] CellCap = rhcs_pkg::COUNT_W'(CellCapInt);
    localparam logic [rhcs_pkg::SUM_W-1:0]   SumCap  = rhcs_pkg::SUM_W'(SumCapLong);

    logic             odd_phase_reg, odd_phase_next;
    logic [7:0]       held_low_reg, held_low_next;
    rhcs_pkg::stats_t stats_reg, stats_next;

    logic [rhcs_pkg::CELL_W-1:0] cell_value;
    logic [rhcs_pkg::SUM_W:0]    sum_wide;

    rhcs_pkg::stats_t stats_init;

    always_comb begin
        stats_init               = '0;
        stats_init.min_cell      = rhcs_pkg::CELL_MAX;
    end

    assign cell_value = {step.data, held_low_reg};
    assign sum_wide   = {1'b0, stats_reg.cell_sum} + {12'd0, cell_value};

    // stats after this byte, valid when a byte is stepped in
    always_comb begin
        stats_upd = stats_reg;
        if (odd_phase_reg) begin
            if (stats_reg.cell_count < CellCap) begin
                stats_upd.cell_count = stats_reg.cell_count + rhcs_pkg::COUNT_W'(1);
            end
            if (cell_value != '0 && stats_reg.nonzero_count < CellCap) begin
                stats_upd.nonzero_count = stats_reg.nonzero_count + rhcs_pkg::COUNT_W'(1);
            end
            if (cell_value < stats_reg.min_cell) begin
                stats_upd.min_cell = cell_value;
            end
            if (cell_value > stats_reg.max_cell) begin
                stats_upd.max_cell = cell_value;
            end
            if (sum_wide > {1'b0, SumCap}) begin
                stats_upd.cell_sum = SumCap;
            end else begin
                stats_upd.cell_sum = sum_wide[rhcs_pkg::SUM_W-1:0];
            end
        end
    end

    always_comb begin
        odd_phase_next = odd_phase_reg;
        held_low_next  = held_low_reg;
        stats_next     = stats_reg;
        if (step.valid) begin
            if (step.last) begin
                // re-arm for the next report
                odd_phase_next = 1'b0;
                held_low_next  = '0;
                stats_next     = stats_init;
            end else begin
                odd_phase_next = !odd_phase_reg;
                stats_next     = stats_upd;
                if (!odd_phase_reg) begin
                    held_low_next = step.data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odd_phase_reg <= 1'b0;
            held_low_reg  <= '0;
            stats_reg     <= stats_init;
        end else begin
            odd_phase_reg <= odd_phase_next;
            held_low_reg  <= held_low_next;
            stats_reg     <= stats_next;
        end
    end

endmodule

[sv/report_hash_and_cell_stats.sv]
`timescale 1ns / 1ps

// channel   ports            contents
// -------   --------------   ----------------------------------------------------
// input     s_axis_*         tdata: data_byte[7:0]; tlast: last_byte
// result    m_axis_*         tdata: hash_value, cell_count, nonzero_count,
//                            min_cell, max_cell, cell_sum (low bits first)
//
// one byte is taken per cycle; the path is input register, one pass of the
// hash multiply and cell compare/add, then the result register
// the result is registered when the last byte leaves the input register
// aresetn clears the input and result valids and restarts the accumulators
// a waiting result stalls the input only when the next last byte arrives

module report_hash_and_cell_stats #(
    parameter int MAX_REPORT_BYTES = rhcs_pkg::MAX_REPORT_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // data_byte[7:0]
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // hash_value[31:0], cell_count[43:32], nonzero_count[55:44],
    // min_cell[71:56], max_cell[87:72], cell_sum[114:88], zero pad
    output logic [rhcs_pkg::TDATA_W-1:0] m_axis_tdata
);

    logic       in_valid_reg, in_valid_next;
    logic       in_last_reg;
    logic [7:0] in_data_reg;

    logic out_valid_reg, out_valid_next;
    logic [rhcs_pkg::TDATA_W-1:0] out_data_reg;

    logic                        consume;
    logic                        s_xfer;
    rhcs_pkg::step_t             step;
    logic [rhcs_pkg::HASH_W-1:0] hash_upd;
    rhcs_pkg::stats_t            stats_upd;

    // a last byte needs a free result slot, other bytes always go through
    assign consume = in_valid_reg && !(in_last_reg && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;
    assign s_xfer = s_axis_tvalid && s_axis_tready;

    assign step.valid = consume;
    assign step.last  = in_last_reg;
    assign step.data  = in_data_reg;

    rhcs_fnv u_fnv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .hash_upd (hash_upd)
    );

    rhcs_cell_stats #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_cell_stats (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .stats_upd (stats_upd)
    );

    always_comb begin
        in_valid_next = s_xfer || (in_valid_reg && !consume);
    end

    always_comb begin
        out_valid_next = (consume && in_last_reg) || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (consume && in_last_reg) begin
            out_data_reg <= {{rhcs_pkg::RESULT_PAD{1'b0}},
                             stats_upd.cell_sum,
                             stats_upd.max_cell,
                             stats_upd.min_cell,
                             stats_upd.nonzero_count,
                             stats_upd.cell_count,
                             hash_upd};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_last_reg |=> m_axis_tvalid)
        else $error("no result after a last byte");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |-> !(consume && in_last_reg))
        else $error("pending result overwritten");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty input register");

    a_nonzero_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_last_reg |-> stats_upd.nonzero_count <= stats_upd.cell_count)
        else $error("nonzero count above cell count");

endmodule

[dv/report_hash_and_cell_stats_test.sv]
`timescale 1ns / 1ps

module report_hash_and_cell_stats_test;

    localparam int     CELL_CAP    = (rhcs_pkg::MAX_REPORT_BYTES_DEF / 2 > 4095) ? 4095
                                     : rhcs_pkg::MAX_REPORT_BYTES_DEF / 2;
    localparam longint SUM_CAP_RAW = longint'(CELL_CAP) * 65535;
    localparam longint SUM_CAP     = (SUM_CAP_RAW > 64'h7ffffff) ? 64'h7ffffff : SUM_CAP_RAW;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } report_byte_t;

    typedef struct {
        logic [rhcs_pkg::HASH_W-1:0]  hash;
        logic [rhcs_pkg::COUNT_W-1:0] cells;
        logic [rhcs_pkg::COUNT_W-1:0] nonzero;
        logic [rhcs_pkg::CELL_W-1:0]  lo;
        logic [rhcs_pkg::CELL_W-1:0]  hi;
        logic [rhcs_pkg::SUM_W-1:0]   sum;
    } report_stats_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'd0;    // data_byte[7:0]
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // hash_value[31:0], cell_count[43:32], nonzero_count[55:44],
    // min_cell[71:56], max_cell[87:72], cell_sum[114:88], zero pad
    logic [rhcs_pkg::TDATA_W-1:0] m_axis_tdata;

    report_byte_t  report_bytes_q[$];
    report_stats_t pending_reports[$];

    int send_idle_pct = 22;
    int recv_idle_pct = 61;
    int mismatch_count = 0;
    int rx_stall_left = 0;
    logic rx_stall_kick = 1'b0;

    // running image of the accumulators
    logic [31:0] acc_hash;
    logic [7:0]  pending_low;
    logic        have_low;
    int          n_cells;
    int          n_nonzero;
    logic [15:0] cell_min;
    logic [15:0] cell_max;
    longint      cell_total;

    report_hash_and_cell_stats DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void clear_accumulators();
        acc_hash    = rhcs_pkg::FNV_BASIS;
        pending_low = 8'd0;
        have_low    = 1'b0;
        n_cells     = 0;
        n_nonzero   = 0;
        cell_min    = rhcs_pkg::CELL_MAX;
        cell_max    = 16'd0;
        cell_total  = 0;
    endfunction

    function automatic void fold_report_byte(input logic [7:0] b, input logic last);
        logic [15:0]   cell_value;
        report_stats_t r;
        acc_hash = (acc_hash ^ {24'd0, b}) * rhcs_pkg::FNV_PRIME;
        if (have_low) begin
            cell_value = {b, pending_low};
            if (n_cells < CELL_CAP)
                n_cells++;
            if (cell_value != 16'd0 && n_nonzero < CELL_CAP)
                n_nonzero++;
            if (cell_value < cell_min)
                cell_min = cell_value;
            if (cell_value > cell_max)
                cell_max = cell_value;
            cell_total = cell_total + cell_value;
            if (cell_total > SUM_CAP)
                cell_total = SUM_CAP;
            have_low = 1'b0;
        end else begin
            pending_low = b;
            have_low    = 1'b1;
        end
        if (last) begin
            r.hash    = acc_hash;
            r.cells   = rhcs_pkg::COUNT_W'(n_cells);
            r.nonzero = rhcs_pkg::COUNT_W'(n_nonzero);
            r.lo      = cell_min;
            r.hi      = cell_max;
            r.sum     = rhcs_pkg::SUM_W'(cell_total);
            pending_reports.push_back(r);
            clear_accumulators();
        end
    endfunction

    function automatic void check_report_result(input logic [rhcs_pkg::TDATA_W-1:0] d);
        report_stats_t got;
        report_stats_t want;
        got.hash    = d[31:0];
        got.cells   = d[43:32];
        got.nonzero = d[55:44];
        got.lo      = d[71:56];
        got.hi      = d[87:72];
        got.sum     = d[114:88];
        if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result transfer: hash %h cells %0d", got.hash, got.cells);
        end else begin
            want = pending_reports.pop_front();
            if (got.hash != want.hash || got.cells != want.cells || got.nonzero != want.nonzero ||
                got.lo != want.lo || got.hi != want.hi || got.sum != want.sum) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected hash %h cells %0d nonzero %0d min %h max %h sum %0d",
                             want.hash, want.cells, want.nonzero, want.lo, want.hi, want.sum);
                    $display("  actual   hash %h cells %0d nonzero %0d min %h max %h sum %0d",
                             got.hash, got.cells, got.nonzero, got.lo, got.hi, got.sum);
                end
            end
        end
    endfunction

    // driver: one pending byte at a time, predicted when the transfer happens
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                fold_report_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (report_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= report_bytes_q[0].data;
                    s_axis_tlast  <= report_bytes_q[0].last;
                    void'(report_bytes_q.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (!aresetn)
            rx_stall_left <= 0;
        else if (rx_stall_kick)
            rx_stall_left <= 300;
        else if (rx_stall_left > 0)
            rx_stall_left <= rx_stall_left - 1;
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_report_result(m_axis_tdata);
            m_axis_tready <= (rx_stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        report_byte_t item;
        item.data = b;
        item.last = last;
        report_bytes_q.push_back(item);
    endtask

    task automatic queue_random_reports(input int byte_budget);
        int queued;
        int len;
        int mode;
        int sel;
        logic [7:0] b;
        queued = 0;
        while (queued < byte_budget) begin
            sel = $urandom_range(99);
            if (sel < 70)
                len = $urandom_range(16, 1);
            else if (sel < 95)
                len = $urandom_range(64, 17);
            else
                len = $urandom_range(300, 65);
            mode = $urandom_range(9);
            for (int i = 0; i < len; i++) begin
                if (mode == 0)
                    b = 8'h00;
                else if (mode == 1)
                    b = 8'hff;
                else if ($urandom_range(7) == 0)
                    b = 8'h00;
                else
                    b = 8'($urandom);
                push_byte(b, i == len - 1);
            end
            queued += len;
        end
    endtask

    // wait until every queued byte went out and every result came back, or a timeout
    task automatic drain_reports();
        int waited;
        waited = 0;
        while ((report_bytes_q.size() > 0 || s_axis_tvalid || pending_reports.size() > 0) &&
               waited < 400000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        clear_accumulators();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single byte: hashed, no cell
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b1);
        // one full-scale cell, one zero cell
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // odd final byte
        push_byte(8'h34, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'hab, 1'b1);
        // byte order of a cell: 0x0001 then 0x8000
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b1);
        drain_reports();

        queue_random_reports(520);
        drain_reports();

        send_idle_pct = 61;
        recv_idle_pct = 22;
        queue_random_reports(520);
        drain_reports();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_reports(500);
        drain_reports();

        // receiver holds off while short reports keep coming
        rx_stall_kick = 1'b1;
        @(negedge aclk);
        rx_stall_kick = 1'b0;
        for (int k = 0; k < 80; k++) begin
            int len;
            len = $urandom_range(3, 1);
            for (int i = 0; i < len; i++)
                push_byte(8'($urandom), i == len - 1);
        end
        drain_reports();

        send_idle_pct = 22;
        recv_idle_pct = 22;
        queue_random_reports(80);
        drain_reports();

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_reports.size() == 0 && report_bytes_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
